// ===== hw/rtl/address_bar_codeword_generator_defines.svh =====
// Assertion macros shared by the checker.
`ifndef ADDRESS_BAR_CODEWORD_GENERATOR_DEFINES_SVH
`define ADDRESS_BAR_CODEWORD_GENERATOR_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define ABCG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ABCG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks across reset.
`define ABCG_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/abcg_pkg.sv =====
`default_nettype none

package abcg_pkg;

    localparam int unsigned ADDR_W  = 14;
    localparam int unsigned WORD_W  = 24;
    localparam int unsigned IDX_W   = 15;

    localparam logic [WORD_W-1:0] START_WORD = 24'h0003FF;
    localparam logic [10:0]       GEN_BASE   = 11'h769;
    localparam logic [12:0]       GEN_MASK0  = 13'h1FFF;
    localparam logic [10:0]       GEN_BITS   = 11'h651;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_STEP
    } abcg_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/abcg_step.sv =====
`default_nettype none

// One generator step: next codeword from the previous one and step index.
module abcg_step (
    input  wire logic [abcg_pkg::WORD_W-1:0] prev_word,
    input  wire logic [abcg_pkg::IDX_W-1:0]  step_idx,
    output logic      [abcg_pkg::WORD_W-1:0] next_word
);
    import abcg_pkg::*;

    logic [3:0]        tz;
    logic [3:0]        k0;
    logic [WORD_W-1:0] base_ext;
    logic [WORD_W-1:0] w;

    always_comb begin
        // trailing zero count of the index (index is never zero in use)
        tz = 4'd15;
        for (int j = IDX_W - 1; j >= 0; j--) begin
            if (step_idx[j]) begin
                tz = 4'(j);
            end
        end
    end

    // first generator bit whose mask test passes; base doubles from there on
    assign k0 = (tz >= 4'd13) ? 4'd0 : 4'd13 - tz;
    assign base_ext = {{(WORD_W-11){1'b0}}, GEN_BASE};

    always_comb begin
        w = prev_word ^ (base_ext << tz);
        for (int k = 0; k < 11; k++) begin
            if ((4'(k) >= k0) && GEN_BITS[k]
                    && ((step_idx[12:0] & (GEN_MASK0 >> k)) == 13'd0)) begin
                w = w ^ (base_ext << (4'(k) - k0));
            end
        end
    end

    assign next_word = w;

endmodule

`default_nettype wire

// ===== hw/rtl/address_bar_codeword_generator.sv =====
// Address-bar codeword generator.
// Input channel s_*: one word carries s_req_address. Output channel m_*: one
// word carries the codewords for that address (m_codeword_here) and for the
// next one (m_codeword_after). Both use valid/ready.
// The held codeword pair is advanced by one step of a shared step unit per
// clock. A request above the held address steps forward from the held pair,
// a request below it (or a pending recompute) restarts at index 1, and a
// request equal to a nonzero held address runs no steps.
// A word runs one step per index from its start index to address + 1:
// none for a repeated nonzero address, address + 1 after a restart. Its
// result is then loaded into the output register, and only after that is
// the next word accepted: s_ready is high only in the idle state, not
// while an item is stepped or waits for the output register. A finished
// result waits there while m_ready is low; a new word may be accepted
// meanwhile, and its result is held back until the register frees.
// Reset (aresetn low, synchronous) empties the output and sets both held
// codewords to 0x3FF, so the first request restarts from index 1.
`default_nettype none

module address_bar_codeword_generator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [abcg_pkg::ADDR_W-1:0]   s_req_address,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [abcg_pkg::WORD_W-1:0]   m_codeword_here,
    output logic      [abcg_pkg::WORD_W-1:0]   m_codeword_after
);
    import abcg_pkg::*;

    abcg_state_t       state_reg, state_next;
    logic [WORD_W-1:0] low_reg, low_next;
    logic [WORD_W-1:0] high_reg, high_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  end_reg, end_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] here_reg, here_next;
    logic [WORD_W-1:0] after_reg, after_next;

    logic [WORD_W-1:0] step_word;
    logic [ADDR_W-1:0] lo_addr;
    logic              hit;
    logic              out_free;

    abcg_step u_step (
        .prev_word (high_reg),
        .step_idx  (idx_reg),
        .next_word (step_word)
    );

    assign lo_addr  = low_reg[WORD_W-1:WORD_W-ADDR_W];
    assign hit      = (lo_addr == s_req_address) && (s_req_address != '0);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            low_reg     <= START_WORD;
            high_reg    <= START_WORD;
            idx_reg     <= '0;
            end_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            idx_reg     <= idx_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        here_reg  <= here_next;
        after_reg <= after_next;
    end

    always_comb begin
        state_next   = state_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        idx_next     = idx_reg;
        end_next     = end_reg;
        here_next    = here_reg;
        after_next   = after_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_STEP;
                    end_next   = {1'b0, s_req_address} + IDX_W'(1);
                    if (hit) begin
                        // held pair already answers; empty step range
                        idx_next = IDX_W'(1);
                        end_next = '0;
                    end else if ((lo_addr < s_req_address) && (high_reg != START_WORD)) begin
                        idx_next = {1'b0, high_reg[WORD_W-1:WORD_W-ADDR_W]} + IDX_W'(1);
                    end else begin
                        idx_next  = IDX_W'(1);
                        high_next = START_WORD;
                    end
                end
            end
            ST_STEP: begin
                if (idx_reg <= end_reg) begin
                    low_next  = high_reg;
                    high_next = step_word;
                    idx_next  = idx_reg + IDX_W'(1);
                end else if (out_free) begin
                    here_next    = low_reg;
                    after_next   = high_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_codeword_here  = here_reg;
    assign m_codeword_after = after_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/abcg_checker.sv =====
`default_nettype none

`include "address_bar_codeword_generator_defines.svh"

module abcg_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic [abcg_pkg::ADDR_W-1:0] s_req_address,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [abcg_pkg::WORD_W-1:0] m_codeword_here,
    input wire logic [abcg_pkg::WORD_W-1:0] m_codeword_after
);

    // stalled result word holds
    `ABCG_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_codeword_here) && $stable(m_codeword_after), "result word changed while stalled")

    // input is never ready right after an accepted word
    `ABCG_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after an accept")

    // a fresh result is only loaded while an item is in progress
    `ABCG_ASSERT_IMP(a_rise_from_busy, aclk, aresetn, $rose(m_valid), !$past(s_ready), "result appeared without a busy cycle")

    // reset empties the output
    `ABCG_ASSERT_NXT_ALL(a_reset_empty, aclk, !aresetn, !m_valid, "output valid after reset")

    // waiting request word holds
    `ABCG_ASSERT_NXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_req_address), "request word changed while waiting")

endmodule

bind address_bar_codeword_generator abcg_checker u_abcg_checker (.*);

`default_nettype wire

// ===== verif/address_bar_codeword_checker.sv =====
module address_bar_codeword_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [abcg_pkg::ADDR_W-1:0]   s_req_address,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [abcg_pkg::WORD_W-1:0]   m_codeword_here,
    input  wire logic [abcg_pkg::WORD_W-1:0]   m_codeword_after,
    output int                                 error_count,
    output int                                 words_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import abcg_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] here;
        logic [WORD_W-1:0] after;
    } codeword_pair_t;

    codeword_pair_t    expected_pairs[$];
    logic [WORD_W-1:0] model_low;
    logic [WORD_W-1:0] model_high;

    initial begin
        error_count   = 0;
        words_pending = 0;
        model_low     = START_WORD;
        model_high    = START_WORD;
    end

    // One generator step from index idx applied to the previous codeword.
    function automatic logic [WORD_W-1:0] advance_codeword(input logic [WORD_W-1:0] prev,
                                                           input logic [31:0] idx);
        logic [31:0] base;
        logic [31:0] word;
        logic [31:0] mask;
        logic [31:0] bits;
        base = 32'(GEN_BASE);
        word = {8'b0, prev} ^ ((idx & (~idx + 32'd1)) * base);
        mask = 32'(GEN_MASK0);
        bits = 32'(GEN_BITS);
        while (bits != 0) begin
            if ((idx & mask) == 0) begin
                if (bits[0])
                    word ^= base;
                base = base << 1;
            end
            mask = mask >> 1;
            bits = bits >> 1;
        end
        return word[WORD_W-1:0];
    endfunction

    task automatic predict_pair(input logic [ADDR_W-1:0] addr, output codeword_pair_t pair);
        logic [ADDR_W-1:0] low_addr;
        logic [31:0]       first_idx;
        logic [31:0]       idx;
        low_addr = model_low[WORD_W-1:10];
        if (!(low_addr == addr && addr != 0)) begin
            if (low_addr < addr && model_high != START_WORD) begin
                first_idx = 32'(model_high[WORD_W-1:10]) + 32'd1;
            end else begin
                // restart from the first index
                first_idx  = 32'd1;
                model_high = START_WORD;
            end
            for (idx = first_idx; idx <= 32'(addr) + 32'd1; idx++) begin
                model_low  = model_high;
                model_high = advance_codeword(model_low, idx);
            end
        end
        pair.here  = model_low;
        pair.after = model_high;
    endtask

    always @(posedge aclk) begin
        codeword_pair_t pair;
        if (!aresetn) begin
            model_low  = START_WORD;
            model_high = START_WORD;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pairs.size() == 0) begin
                    $error("unexpected result word: here %h after %h",
                           m_codeword_here, m_codeword_after);
                    error_count++;
                end else begin
                    pair = expected_pairs.pop_front();
                    if (m_codeword_here !== pair.here) begin
                        $error("m_codeword_here: expected %h, actual %h",
                               pair.here, m_codeword_here);
                        error_count++;
                    end
                    if (m_codeword_after !== pair.after) begin
                        $error("m_codeword_after: expected %h, actual %h",
                               pair.after, m_codeword_after);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_pair(s_req_address, pair);
                expected_pairs.push_back(pair);
            end
        end
        words_pending = expected_pairs.size();
    end

endmodule

// ===== verif/tb_address_bar_codeword_generator.sv =====
module tb_address_bar_codeword_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import abcg_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [ADDR_W-1:0]   s_req_address = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [WORD_W-1:0]   m_codeword_here;
    logic [WORD_W-1:0]   m_codeword_after;
    int                  error_count;
    int                  words_pending;

    int send_idle_pct = 12;
    int recv_idle_pct = 80;

    always #5 aclk = ~aclk;

    address_bar_codeword_generator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_address    (s_req_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_codeword_here  (m_codeword_here),
        .m_codeword_after (m_codeword_after)
    );

    address_bar_codeword_checker checker_inst (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_address    (s_req_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_codeword_here  (m_codeword_here),
        .m_codeword_after (m_codeword_after),
        .error_count      (error_count),
        .words_pending    (words_pending)
    );

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic [ADDR_W-1:0] addr);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_address <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Runs of mostly consecutive addresses with repeats, skips and short
    // backward jumps; a few runs start anywhere in the address space.
    task automatic run_phase(input int send_pct, input int recv_pct, input int n_words);
        int                sent;
        int                run_len;
        int                far_left;
        int                pick;
        logic [ADDR_W-1:0] addr;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        far_left      = 4;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            if (pick < 6 && far_left > 0) begin
                addr = ADDR_W'($urandom());
                far_left--;
            end else begin
                addr = ADDR_W'($urandom_range(0, 63));
            end
            run_len = $urandom_range(3, 20);
            if (run_len > n_words - sent)
                run_len = n_words - sent;
            repeat (run_len) begin
                send_word(addr);
                sent++;
                pick = $urandom_range(99);
                if (pick < 78)
                    addr = addr + ADDR_W'(1);
                else if (pick < 88)
                    addr = addr;
                else if (pick < 94)
                    addr = addr + ADDR_W'($urandom_range(2, 6));
                else if (addr >= 4 && addr < 1024)
                    addr = addr - ADDR_W'($urandom_range(1, 4));
                else
                    addr = ADDR_W'($urandom_range(0, 15));
            end
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] directed[$];
        directed = '{14'd0, 14'd0, 14'd1, 14'd2, 14'd2, 14'd3, 14'd7, 14'd4, 14'd5,
                     14'h3FFF, 14'h3FFF, 14'h3FFE, 14'h3FFF, 14'd0, 14'h2AAA,
                     14'h1555, 14'h1556, 14'd1, 14'd0, 14'd0, 14'd1};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[k])
            send_word(directed[k]);

        run_phase(12, 80, 145);
        run_phase(80, 12, 145);
        run_phase(0, 0, 145);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (words_pending == 0);
        repeat (20) @(posedge aclk);
        if (error_count == 0 && words_pending == 0)
            $display("PASS address_bar_codeword_generator");
        else
            $display("FAIL address_bar_codeword_generator");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL address_bar_codeword_generator");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/abcg_pkg.sv
hw/rtl/abcg_step.sv
hw/rtl/address_bar_codeword_generator.sv
hw/rtl/abcg_checker.sv
verif/address_bar_codeword_checker.sv
verif/tb_address_bar_codeword_generator.sv
